### hdl/fpes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpes_pkg;

  localparam int ADDR_W    = 20;
  localparam int CHIP_SPAN = 262144;
  localparam int SPAN_W    = $clog2(CHIP_SPAN);
  localparam int RES_MAX   = 9;
  localparam int RES_IDX_W = $clog2(RES_MAX);
  localparam int RES_CNT_W = $clog2(RES_MAX + 1);
  localparam int SIZE_W    = ADDR_W + 1;
  localparam logic [SIZE_W-1:0] FLASH_CAP = SIZE_W'(1 << ADDR_W);

  // request codes
  localparam logic [1:0] REQ_PROG  = 2'd0;
  localparam logic [1:0] REQ_ERASE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_RESET = 2'd3;

  // result op codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_DELAY = 2'd2;
  localparam logic [1:0] OP_DONE  = 2'd3;

  // register indexes
  localparam logic [2:0] CFG_FLASH_SIZE = 3'd0;
  localparam logic [2:0] CFG_PROG_LIMIT = 3'd1;
  localparam logic [2:0] CFG_ERASE_LIM  = 3'd2;
  localparam logic [2:0] CFG_PROG_DLY   = 3'd3;
  localparam logic [2:0] CFG_VERIFY_DLY = 3'd4;
  localparam logic [2:0] CFG_ERASE_DLY  = 3'd5;

  // flash command words
  localparam logic [15:0] CMD_PROG      = 16'h4040;
  localparam logic [15:0] CMD_PVERIFY   = 16'hc0c0;
  localparam logic [15:0] CMD_ERASE     = 16'h2020;
  localparam logic [15:0] CMD_EVERIFY   = 16'ha0a0;
  localparam logic [15:0] CMD_RESET     = 16'hffff;
  localparam logic [15:0] MASK_PROG_HI  = 16'h40ff;
  localparam logic [15:0] MASK_VER_HI   = 16'hc0ff;
  localparam logic [15:0] MASK_PROG_LO  = 16'hff40;
  localparam logic [15:0] MASK_VER_LO   = 16'hffc0;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PROG,
    PH_BLANK,
    PH_ZERO,
    PH_VERIFY
  } phase_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] target_address;
    logic [15:0]       write_value;
    logic [15:0]       read_value;
  } req_t;

  typedef struct packed {
    logic [1:0]        op_kind;
    logic [ADDR_W-1:0] bus_address;
    logic [15:0]       bus_data;
    logic [15:0]       delay_count;
    logic              status;
    logic              last;
  } res_t;

  function automatic res_t mk_res(logic [1:0] k, logic [ADDR_W-1:0] a, logic [15:0] d,
                                  logic [15:0] dl, logic st);
    res_t r;
    r.op_kind     = k;
    r.bus_address = a;
    r.bus_data    = d;
    r.delay_count = dl;
    r.status      = st;
    r.last        = 1'b0;
    return r;
  endfunction

  // program pulse: setup, data, delay, verify, delay, read
  function automatic res_t pulse_op(logic [2:0] i, logic [ADDR_W-1:0] a, logic [15:0] pw,
                                    logic [15:0] v, logic [15:0] pd, logic [15:0] vw,
                                    logic [15:0] vd);
    res_t r;
    case (i)
      3'd0:    r = mk_res(OP_WRITE, a, pw, 16'd0, 1'b0);
      3'd1:    r = mk_res(OP_WRITE, a, v, 16'd0, 1'b0);
      3'd2:    r = mk_res(OP_DELAY, '0, 16'd0, pd, 1'b0);
      3'd3:    r = mk_res(OP_WRITE, a, vw, 16'd0, 1'b0);
      3'd4:    r = mk_res(OP_DELAY, '0, 16'd0, vd, 1'b0);
      default: r = mk_res(OP_READ, a, 16'd0, 16'd0, 1'b0);
    endcase
    return r;
  endfunction

  // erase pair, delay, then erase verify (entries 3..5 are the verify alone)
  function automatic res_t erase_op(logic [2:0] i, logic [ADDR_W-1:0] a, logic [15:0] ed,
                                    logic [15:0] vd);
    res_t r;
    case (i)
      3'd0, 3'd1: r = mk_res(OP_WRITE, a, CMD_ERASE, 16'd0, 1'b0);
      3'd2:       r = mk_res(OP_DELAY, '0, 16'd0, ed, 1'b0);
      3'd3:       r = mk_res(OP_WRITE, a, CMD_EVERIFY, 16'd0, 1'b0);
      3'd4:       r = mk_res(OP_DELAY, '0, 16'd0, vd, 1'b0);
      default:    r = mk_res(OP_READ, a, 16'd0, 16'd0, 1'b0);
    endcase
    return r;
  endfunction

  // two reset writes to each chip base
  function automatic res_t reset_op(logic [2:0] i);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(CHIP_SPAN * int'(i[2:1]));
    return mk_res(OP_WRITE, a, CMD_RESET, 16'd0, 1'b0);
  endfunction

endpackage

`default_nettype wire

### hdl/flash_program_erase_sequencer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Program/erase sequencer for byte-wide flash chips, ganged in pairs on a 16-bit bus.
// Each input transfer (program, erase, reset, or read-back data) is captured in an
// input register, then turned into a list of up to nine bus operations (write,
// read, delay, done) held in a result buffer. The buffer drains one result transfer
// per cycle while out_stall is low, with last set on the final result of the item.
// The next item is loaded into the buffer in the same cycle its last result is
// taken, so single-result items (the usual read-back case) flow at one per cycle
// while the output is not stalled. A read-back with no read pending gives no
// results. Configuration writes are always ready and must only be made while the
// block is idle.
module flash_program_erase_sequencer_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_vld,
  output logic                     in_stall,
  input  wire fpes_pkg::req_t      in_data,
  output logic                     out_vld,
  input  wire logic                out_stall,
  output fpes_pkg::res_t           out_data,
  input  wire logic                cfg_vld,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [20:0]         cfg_data
);
  import fpes_pkg::*;

  // configuration
  logic [SIZE_W-1:0] flash_size_r;
  logic [5:0]        prog_limit_r;
  logic [11:0]       erase_limit_r;
  logic [15:0]       prog_dly_r, verify_dly_r, erase_dly_r;

  // input stage
  logic in_vld_r;
  req_t in_r;

  // sequencer state
  phase_t            phase_r, phase_nxt;
  logic [5:0]        prog_tries_r, prog_tries_nxt;
  logic [11:0]       erase_tries_r, erase_tries_nxt;
  logic [ADDR_W-1:0] walk_r, walk_nxt;
  logic [ADDR_W-1:0] pend_addr_r, pend_addr_nxt;
  logic [15:0]       pend_val_r, pend_val_nxt;
  logic [15:0]       prog_word_r, prog_word_nxt;
  logic [15:0]       ver_word_r, ver_word_nxt;
  logic              erased_r, erased_nxt;

  // result buffer
  res_t               buf_r [RES_MAX];
  res_t               res   [RES_MAX];
  logic [RES_CNT_W-1:0] cnt_r, res_cnt;
  logic [RES_IDX_W-1:0] rd_r;

  // decode
  logic [SIZE_W-1:0] size_eff, next_walk;
  logic              at_end, rv_match, rv_blank, give_up, erase_lim_hit;
  logic [5:0]        tries_inc;
  logic [15:0]       retry_pw, retry_vw;
  logic              out_xfer, rd_last, buf_free, load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flash_size_r  <= FLASH_CAP;
      prog_limit_r  <= 6'd50;
      erase_limit_r <= 12'd3000;
      prog_dly_r    <= 16'd14;
      verify_dly_r  <= 16'd12;
      erase_dly_r   <= 16'd11000;
    end else if (cfg_vld && cfg_ready) begin
      case (cfg_index)
        CFG_FLASH_SIZE: flash_size_r  <= cfg_data;
        CFG_PROG_LIMIT: prog_limit_r  <= cfg_data[5:0];
        CFG_ERASE_LIM:  erase_limit_r <= cfg_data[11:0];
        CFG_PROG_DLY:   prog_dly_r    <= cfg_data[15:0];
        CFG_VERIFY_DLY: verify_dly_r  <= cfg_data[15:0];
        CFG_ERASE_DLY:  erase_dly_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // handshake: the buffer frees up when empty or when its last result is taken
  assign out_vld  = (cnt_r != '0);
  assign out_xfer = out_vld && !out_stall;
  assign rd_last  = (RES_CNT_W'(rd_r) == cnt_r - RES_CNT_W'(1));
  assign buf_free = (cnt_r == '0) || (out_xfer && rd_last);
  assign load     = in_vld_r && buf_free;
  assign in_stall = in_vld_r && !buf_free;

  always_comb begin
    out_data      = buf_r[rd_r];
    out_data.last = rd_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_vld && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (load) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld && !in_stall) begin
      in_r <= in_data;
    end
  end

  // shared decode of the captured item against current state
  always_comb begin
    size_eff      = (flash_size_r > FLASH_CAP) ? FLASH_CAP : flash_size_r;
    next_walk     = {1'b0, walk_r} + SIZE_W'(2);
    at_end        = (next_walk >= size_eff);
    rv_match      = (in_r.read_value == pend_val_r);
    rv_blank      = (in_r.read_value == CMD_RESET);
    tries_inc     = prog_tries_r + 6'd1;
    give_up       = (tries_inc >= prog_limit_r) || (tries_inc == 6'd0);
    erase_lim_hit = !(erase_tries_r < erase_limit_r);
    // retry only the failing byte lane
    retry_pw = CMD_RESET;
    retry_vw = CMD_RESET;
    if (in_r.read_value[15:8] != pend_val_r[15:8]) begin
      retry_pw = retry_pw & MASK_PROG_HI;
      retry_vw = retry_vw & MASK_VER_HI;
    end
    if (in_r.read_value[7:0] != pend_val_r[7:0]) begin
      retry_pw = retry_pw & MASK_PROG_LO;
      retry_vw = retry_vw & MASK_VER_LO;
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (in_r.req_type)
      REQ_PROG:  phase_nxt = PH_PROG;
      REQ_ERASE: phase_nxt = (size_eff == '0) ? PH_IDLE : PH_BLANK;
      REQ_RESET: phase_nxt = PH_IDLE;
      default: begin
        case (phase_r)
          PH_PROG:   if (rv_match || give_up) phase_nxt = PH_IDLE;
          PH_BLANK: begin
            if (!rv_blank) phase_nxt = PH_ZERO;
            else if (at_end) phase_nxt = PH_IDLE;
          end
          PH_ZERO: begin
            if (rv_match) begin
              if (at_end) phase_nxt = PH_VERIFY;
            end else if (give_up) begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_VERIFY: begin
            if (!rv_blank) begin
              if (erase_lim_hit) phase_nxt = PH_IDLE;
            end else if (at_end) begin
              phase_nxt = PH_IDLE;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    endcase
  end

  // result list and data state
  always_comb begin
    for (int i = 0; i < RES_MAX; i++) res[i] = '0;
    res_cnt         = '0;
    prog_tries_nxt  = prog_tries_r;
    erase_tries_nxt = erase_tries_r;
    walk_nxt        = walk_r;
    pend_addr_nxt   = pend_addr_r;
    pend_val_nxt    = pend_val_r;
    prog_word_nxt   = prog_word_r;
    ver_word_nxt    = ver_word_r;
    erased_nxt      = erased_r;
    case (in_r.req_type)
      REQ_PROG: begin
        pend_addr_nxt  = {in_r.target_address[ADDR_W-1:1], 1'b0};
        pend_val_nxt   = in_r.write_value;
        prog_word_nxt  = CMD_PROG;
        ver_word_nxt   = CMD_PVERIFY;
        prog_tries_nxt = '0;
        res_cnt        = RES_CNT_W'(6);
      end
      REQ_ERASE, REQ_RESET: begin
        for (int i = 0; i < 8; i++) res[i] = reset_op(3'(i));
        res_cnt = RES_CNT_W'(9);
        if (in_r.req_type == REQ_ERASE) begin
          walk_nxt        = '0;
          erase_tries_nxt = '0;
          erased_nxt      = 1'b0;
          res[8] = (size_eff == '0) ? mk_res(OP_DONE, '0, 16'd0, 16'd0, 1'b0)
                                    : mk_res(OP_READ, '0, 16'd0, 16'd0, 1'b0);
        end else begin
          res[8] = mk_res(OP_DONE, '0, 16'd0, 16'd0, 1'b0);
        end
      end
      default: begin
        case (phase_r)
          PH_PROG, PH_ZERO: begin
            if (rv_match && phase_r == PH_PROG) begin
              res[0]  = mk_res(OP_DONE, '0, 16'd0, 16'd0, 1'b0);
              res_cnt = RES_CNT_W'(1);
            end else if (rv_match) begin
              res_cnt = RES_CNT_W'(6);
              if (at_end) begin
                walk_nxt        = '0;
                erase_tries_nxt = '0;
                erased_nxt      = 1'b0;
                for (int i = 0; i < 6; i++)
                  res[i] = erase_op(3'(i), '0, erase_dly_r, verify_dly_r);
              end else begin
                walk_nxt       = next_walk[ADDR_W-1:0];
                pend_addr_nxt  = {next_walk[ADDR_W-1:1], 1'b0};
                pend_val_nxt   = 16'd0;
                prog_word_nxt  = CMD_PROG;
                ver_word_nxt   = CMD_PVERIFY;
                prog_tries_nxt = '0;
              end
            end else begin
              prog_tries_nxt = tries_inc;
              if (give_up) begin
                res[0]  = mk_res(OP_DONE, '0, 16'd0, 16'd0, 1'b1);
                res_cnt = RES_CNT_W'(1);
              end else begin
                prog_word_nxt = retry_pw;
                ver_word_nxt  = retry_vw;
                res_cnt       = RES_CNT_W'(6);
              end
            end
          end
          PH_BLANK: begin
            if (!rv_blank) begin
              walk_nxt       = '0;
              pend_addr_nxt  = '0;
              pend_val_nxt   = 16'd0;
              prog_word_nxt  = CMD_PROG;
              ver_word_nxt   = CMD_PVERIFY;
              prog_tries_nxt = '0;
              res_cnt        = RES_CNT_W'(6);
            end else if (at_end) begin
              res[0]  = mk_res(OP_DONE, '0, 16'd0, 16'd0, 1'b0);
              res_cnt = RES_CNT_W'(1);
            end else begin
              walk_nxt = next_walk[ADDR_W-1:0];
              res[0]   = mk_res(OP_READ, next_walk[ADDR_W-1:0], 16'd0, 16'd0, 1'b0);
              res_cnt  = RES_CNT_W'(1);
            end
          end
          PH_VERIFY: begin
            if (!rv_blank) begin
              if (!erase_lim_hit) begin
                erase_tries_nxt = erase_tries_r + 12'd1;
                erased_nxt      = 1'b0;
                for (int i = 0; i < 6; i++)
                  res[i] = erase_op(3'(i), walk_r, erase_dly_r, verify_dly_r);
                res_cnt = RES_CNT_W'(6);
              end else begin
                res[0]  = mk_res(OP_DONE, '0, 16'd0, 16'd0, 1'b1);
                res_cnt = RES_CNT_W'(1);
              end
            end else if (at_end) begin
              res[0]  = mk_res(OP_DONE, '0, 16'd0, 16'd0, 1'b0);
              res_cnt = RES_CNT_W'(1);
            end else begin
              walk_nxt   = next_walk[ADDR_W-1:0];
              erased_nxt = 1'b0;
              // forced erase at each chip boundary
              if (!erased_r && next_walk[SPAN_W-1:0] == '0) begin
                for (int i = 0; i < 6; i++)
                  res[i] = erase_op(3'(i), next_walk[ADDR_W-1:0], erase_dly_r, verify_dly_r);
                res_cnt = RES_CNT_W'(6);
              end else begin
                for (int i = 0; i < 3; i++)
                  res[i] = erase_op(3'(i + 3), next_walk[ADDR_W-1:0], erase_dly_r,
                                    verify_dly_r);
                res_cnt = RES_CNT_W'(3);
              end
            end
          end
          default: ;
        endcase
      end
    endcase
    // program pulse cases all fill six entries from the updated pending state
    if (res_cnt == RES_CNT_W'(6) && res[0].op_kind == OP_WRITE &&
        res[0].bus_data != CMD_ERASE) begin
      for (int i = 0; i < 6; i++)
        res[i] = pulse_op(3'(i), pend_addr_nxt, prog_word_nxt, pend_val_nxt, prog_dly_r,
                          ver_word_nxt, verify_dly_r);
    end
    if (res_cnt == RES_CNT_W'(6) && res[0].op_kind == OP_READ) begin
      for (int i = 0; i < 6; i++)
        res[i] = pulse_op(3'(i), pend_addr_nxt, prog_word_nxt, pend_val_nxt, prog_dly_r,
                          ver_word_nxt, verify_dly_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      prog_tries_r    <= '0;
      erase_tries_r   <= '0;
      walk_r          <= '0;
      pend_addr_r     <= '0;
      pend_val_r      <= '0;
      prog_word_r     <= CMD_PROG;
      ver_word_r      <= CMD_PVERIFY;
      erased_r        <= 1'b0;
    end else if (load) begin
      phase_r         <= phase_nxt;
      prog_tries_r    <= prog_tries_nxt;
      erase_tries_r   <= erase_tries_nxt;
      walk_r          <= walk_nxt;
      pend_addr_r     <= pend_addr_nxt;
      pend_val_r      <= pend_val_nxt;
      prog_word_r     <= prog_word_nxt;
      ver_word_r      <= ver_word_nxt;
      erased_r        <= erased_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= '0;
    end else if (load) begin
      cnt_r <= res_cnt;
      rd_r  <= '0;
    end else if (out_xfer) begin
      if (rd_last) begin
        cnt_r <= '0;
        rd_r  <= '0;
      end else begin
        rd_r <= rd_r + RES_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < RES_MAX; i++) buf_r[i] <= res[i];
    end
  end

`ifndef SYNTHESIS
  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> (RES_CNT_W'(rd_r) < cnt_r))
    else $error("result read index beyond fill count");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_data.last) |=> (rd_r == '0))
    else $error("read index not restarted after last result");

  a_silent_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (load && res_cnt == '0) |-> (phase_r == PH_IDLE && in_r.req_type == REQ_READ))
    else $error("item without results outside idle read-back");

  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && cnt_r != '0))
    else $error("input stalled with free buffer");
`endif

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import fpes_pkg::*;

  // Cycle limit for the whole run; far above the slowest legal schedule.
  localparam int CYCLE_LIMIT = 600000;
  // Cycles given to the block to settle before a register write or the end.
  localparam int SETTLE = 24;

  logic        clk;
  logic        rst_n;
  logic        in_vld;
  logic        in_stall;
  req_t        in_data;
  logic        out_vld;
  logic        out_stall;
  res_t        out_data;
  logic        cfg_vld;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [20:0] cfg_data;

  flash_program_erase_sequencer_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_vld  (out_vld),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_vld  (cfg_vld),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the sequencer: registers and walk state.
  // ---------------------------------------------------------------------------
  logic [20:0] sh_size;
  logic [5:0]  sh_prog_limit;
  logic [11:0] sh_erase_limit;
  logic [15:0] sh_prog_dly;
  logic [15:0] sh_verify_dly;
  logic [15:0] sh_erase_dly;

  phase_t      ph;
  logic [5:0]  prog_tries;
  logic [11:0] erase_tries;
  logic [19:0] walk;
  logic [19:0] pend_addr;
  logic [15:0] pend_val;
  logic [15:0] prog_word;
  logic [15:0] ver_word;
  logic        erased_recently;

  res_t bus_ops_due[$];   // bus operations still to come out, oldest first
  req_t pend_items[$];    // transfers waiting for the input driver
  int   sent_cnt;
  int   accepted_cnt;
  int   errors;
  int   max_gap;          // 0 gives a stretch with no idling on either side

  function automatic void add_op(logic [1:0] k, logic [19:0] a, logic [15:0] d,
                                 logic [15:0] dl, logic st);
    res_t r;
    r.op_kind     = k;
    r.bus_address = a;
    r.bus_data    = d;
    r.delay_count = dl;
    r.status      = st;
    r.last        = 1'b0;
    bus_ops_due.push_back(r);
  endfunction

  function automatic void add_pulse();
    add_op(OP_WRITE, pend_addr, prog_word, 16'd0, 1'b0);
    add_op(OP_WRITE, pend_addr, pend_val, 16'd0, 1'b0);
    add_op(OP_DELAY, '0, 16'd0, sh_prog_dly, 1'b0);
    add_op(OP_WRITE, pend_addr, ver_word, 16'd0, 1'b0);
    add_op(OP_DELAY, '0, 16'd0, sh_verify_dly, 1'b0);
    add_op(OP_READ, pend_addr, 16'd0, 16'd0, 1'b0);
  endfunction

  function automatic void begin_program(logic [19:0] a, logic [15:0] v);
    pend_addr  = {a[19:1], 1'b0};
    pend_val   = v;
    prog_word  = CMD_PROG;
    ver_word   = CMD_PVERIFY;
    prog_tries = '0;
    add_pulse();
  endfunction

  // 1 when the halfword reads back right, 0 after a retry pulse, -1 on failure
  function automatic int judge_program(logic [15:0] rv);
    if (rv == pend_val) return 1;
    prog_tries = prog_tries + 6'd1;
    if (prog_tries >= sh_prog_limit || prog_tries == 6'd0) return -1;
    prog_word = 16'hffff;
    ver_word  = 16'hffff;
    // only the failing lane gets the command bits
    if (rv[15:8] != pend_val[15:8]) begin
      prog_word &= MASK_PROG_HI;
      ver_word  &= MASK_VER_HI;
    end
    if (rv[7:0] != pend_val[7:0]) begin
      prog_word &= MASK_PROG_LO;
      ver_word  &= MASK_VER_LO;
    end
    add_pulse();
    return 0;
  endfunction

  function automatic void add_verify();
    erased_recently = 1'b0;
    add_op(OP_WRITE, walk, CMD_EVERIFY, 16'd0, 1'b0);
    add_op(OP_DELAY, '0, 16'd0, sh_verify_dly, 1'b0);
    add_op(OP_READ, walk, 16'd0, 16'd0, 1'b0);
  endfunction

  function automatic void add_erase();
    add_op(OP_WRITE, walk, CMD_ERASE, 16'd0, 1'b0);
    add_op(OP_WRITE, walk, CMD_ERASE, 16'd0, 1'b0);
    add_op(OP_DELAY, '0, 16'd0, sh_erase_dly, 1'b0);
    erased_recently = 1'b1;
    add_verify();
  endfunction

  function automatic void add_chip_resets();
    for (int k = 0; k < 4; k++) begin
      add_op(OP_WRITE, 20'(CHIP_SPAN * k), CMD_RESET, 16'd0, 1'b0);
      add_op(OP_WRITE, 20'(CHIP_SPAN * k), CMD_RESET, 16'd0, 1'b0);
    end
  endfunction

  function automatic void add_done(logic st);
    add_op(OP_DONE, '0, 16'd0, 16'd0, st);
    ph = PH_IDLE;
  endfunction

  // Expected bus operations for one accepted request transfer.
  function automatic void predict_bus_ops(req_t q);
    int          prior_cnt;
    int          verdict;
    logic [20:0] span;
    logic [20:0] nxt;
    prior_cnt = bus_ops_due.size();
    span   = (sh_size > FLASH_CAP) ? FLASH_CAP : sh_size;
    nxt    = {1'b0, walk} + 21'd2;
    case (q.req_type)
      REQ_PROG: begin
        ph = PH_PROG;
        begin_program(q.target_address, q.write_value);
      end
      REQ_ERASE: begin
        add_chip_resets();
        walk            = '0;
        erase_tries     = '0;
        erased_recently = 1'b0;
        if (span == 21'd0) begin
          add_done(1'b0);
        end else begin
          ph = PH_BLANK;
          add_op(OP_READ, '0, 16'd0, 16'd0, 1'b0);
        end
      end
      REQ_RESET: begin
        add_chip_resets();
        add_done(1'b0);
      end
      default: begin
        case (ph)
          PH_PROG: begin
            verdict = judge_program(q.read_value);
            if (verdict != 0) add_done(verdict < 0);
          end
          PH_BLANK: begin
            if (q.read_value != 16'hffff) begin
              // not blank: zero every halfword before erasing
              walk = '0;
              ph   = PH_ZERO;
              begin_program('0, 16'd0);
            end else if (nxt >= span) begin
              add_done(1'b0);
            end else begin
              walk = nxt[19:0];
              add_op(OP_READ, walk, 16'd0, 16'd0, 1'b0);
            end
          end
          PH_ZERO: begin
            verdict = judge_program(q.read_value);
            if (verdict < 0) begin
              add_done(1'b1);
            end else if (verdict > 0) begin
              if (nxt >= span) begin
                walk        = '0;
                erase_tries = '0;
                ph          = PH_VERIFY;
                add_erase();
              end else begin
                walk = nxt[19:0];
                begin_program(walk, 16'd0);
              end
            end
          end
          PH_VERIFY: begin
            if (q.read_value != 16'hffff) begin
              if (erase_tries < sh_erase_limit) begin
                erase_tries = erase_tries + 12'd1;
                add_erase();
              end else begin
                add_done(1'b1);
              end
            end else if (nxt >= span) begin
              add_done(1'b0);
            end else begin
              walk = nxt[19:0];
              // forced erase when the walk enters a new chip
              if (!erased_recently && (walk % CHIP_SPAN) == 0) add_erase();
              else add_verify();
            end
          end
          default: ;  // read data with nothing pending
        endcase
      end
    endcase
    if (bus_ops_due.size() > prior_cnt) bus_ops_due[bus_ops_due.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: one request transfer at a time from pend_items.
  // ---------------------------------------------------------------------------
  int in_gap;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_vld <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_vld && !in_stall) begin
        predict_bus_ops(in_data);
        accepted_cnt++;
      end
      if (!in_vld || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_vld <= 1'b0;
        end else if (pend_items.size() > 0) begin
          in_data <= pend_items.pop_front();
          in_vld  <= 1'b1;
          in_gap = $urandom_range(0, max_gap);
        end else begin
          in_vld <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: random stall per result, field-by-field compare.
  // ---------------------------------------------------------------------------
  int out_hold;

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_vld && !out_stall) begin
        if (bus_ops_due.size() == 0) begin
          $error("unexpected result transfer %p", out_data);
          errors++;
        end else begin
          want = bus_ops_due.pop_front();
          if (out_data.op_kind !== want.op_kind) begin
            $error("op_kind exp %0d got %0d", want.op_kind, out_data.op_kind);
            errors++;
          end
          if (out_data.bus_address !== want.bus_address) begin
            $error("bus_address exp %h got %h", want.bus_address, out_data.bus_address);
            errors++;
          end
          if (out_data.bus_data !== want.bus_data) begin
            $error("bus_data exp %h got %h", want.bus_data, out_data.bus_data);
            errors++;
          end
          if (out_data.delay_count !== want.delay_count) begin
            $error("delay_count exp %0d got %0d", want.delay_count, out_data.delay_count);
            errors++;
          end
          if (out_data.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, out_data.status);
            errors++;
          end
          if (out_data.last !== want.last) begin
            $error("last exp %0d got %0d", want.last, out_data.last);
            errors++;
          end
        end
        out_hold = $urandom_range(0, max_gap);
      end
      if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog.
  int cycles;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  // queue only, so queued transfers can go out back to back
  task automatic send(input req_t q);
    pend_items.push_back(q);
    sent_cnt++;
  endtask

  task automatic wait_accepted();
    while (accepted_cnt != sent_cnt) @(posedge clk);
  endtask

  task automatic send_fields(input logic [1:0] k, input logic [19:0] a,
                             input logic [15:0] wv, input logic [15:0] rv);
    req_t q;
    q.req_type       = k;
    q.target_address = a;
    q.write_value    = wv;
    q.read_value     = rv;
    send(q);
  endtask

  // wait for every queued and expected transfer, then let the block settle
  task automatic drain();
    while (pend_items.size() > 0 || accepted_cnt != sent_cnt || bus_ops_due.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [20:0] val);
    @(posedge clk);
    cfg_vld   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_vld <= 1'b0;
    case (idx)
      CFG_FLASH_SIZE: sh_size        = val;
      CFG_PROG_LIMIT: sh_prog_limit  = val[5:0];
      CFG_ERASE_LIM:  sh_erase_limit = val[11:0];
      CFG_PROG_DLY:   sh_prog_dly    = val[15:0];
      CFG_VERIFY_DLY: sh_verify_dly  = val[15:0];
      default:        sh_erase_dly   = val[15:0];
    endcase
  endtask

  task automatic write_all(input logic [20:0] sz, input logic [5:0] pl, input logic [11:0] el,
                           input logic [15:0] pd, input logic [15:0] vd, input logic [15:0] ed);
    drain();
    write_reg(CFG_FLASH_SIZE, sz);
    write_reg(CFG_PROG_LIMIT, 21'(pl));
    write_reg(CFG_ERASE_LIM, 21'(el));
    write_reg(CFG_PROG_DLY, 21'(pd));
    write_reg(CFG_VERIFY_DLY, 21'(vd));
    write_reg(CFG_ERASE_DLY, 21'(ed));
  endtask

  // Read-back that is mostly what the flash should return now, else a lane error.
  function automatic logic [15:0] pick_read();
    logic [15:0] good;
    int          roll;
    good = (ph == PH_PROG || ph == PH_ZERO) ? pend_val : 16'hffff;
    roll = $urandom_range(0, 9);
    if (roll == 7) return good ^ {8'($urandom_range(1, 255)), 8'h00};
    if (roll == 8) return good ^ {8'h00, 8'($urandom_range(1, 255))};
    if (roll == 9) return 16'($urandom);
    return good;
  endfunction

  // One command followed by read-backs until it is done; sometimes abandoned.
  task automatic run_cmd(input logic [1:0] k);
    int          guard;
    int          roll;
    logic [1:0]  kk;
    send_fields(k, 20'($urandom), 16'($urandom), 16'($urandom));
    wait_accepted();
    guard = 0;
    while (ph != PH_IDLE && guard < 80) begin
      roll = $urandom_range(0, 39);
      kk = (roll == 0) ? REQ_PROG : (roll == 1) ? REQ_ERASE : (roll == 2) ? REQ_RESET : REQ_READ;
      send_fields(kk, 20'($urandom), 16'($urandom), pick_read());
      wait_accepted();
      guard++;
    end
    if (ph != PH_IDLE) begin
      send_fields(REQ_RESET, 20'($urandom), 16'($urandom), 16'($urandom));
      wait_accepted();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int          start_cnt;
    logic [1:0]  kind;
    rst_n     = 1'b0;
    in_vld    = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_vld   = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    max_gap   = 12;
    errors    = 0;
    sent_cnt  = 0;
    accepted_cnt = 0;
    cycles    = 0;
    sh_size        = 21'd1048576;
    sh_prog_limit  = 6'd50;
    sh_erase_limit = 12'd3000;
    sh_prog_dly    = 16'd14;
    sh_verify_dly  = 16'd12;
    sh_erase_dly   = 16'd11000;
    ph             = PH_IDLE;
    prog_tries     = '0;
    erase_tries    = '0;
    walk           = '0;
    pend_addr      = '0;
    pend_val       = '0;
    prog_word      = CMD_PROG;
    ver_word       = CMD_PVERIFY;
    erased_recently = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed, reset values of the registers.
    send_fields(REQ_PROG, 20'h00000, 16'h0000, 16'hffff);
    send_fields(REQ_READ, 20'hfffff, 16'hffff, 16'h0000);
    // odd address, then high lane fails, low lane fails, then passes
    send_fields(REQ_PROG, 20'hfffff, 16'hffff, 16'h0000);
    send_fields(REQ_READ, 20'h00000, 16'h0000, 16'h00ff);
    send_fields(REQ_READ, 20'h00000, 16'h0000, 16'hff00);
    send_fields(REQ_READ, 20'h00000, 16'h0000, 16'hffff);
    // both lanes fail, then a reset while busy
    send_fields(REQ_PROG, 20'h12345, 16'ha5a5, 16'h0000);
    send_fields(REQ_READ, 20'h00000, 16'h0000, 16'h0000);
    send_fields(REQ_RESET, 20'h55555, 16'h5a5a, 16'h0000);
    // read data with nothing pending
    send_fields(REQ_READ, 20'haaaaa, 16'h1234, 16'hffff);
    // full-size erase, abandoned by a program command
    send_fields(REQ_ERASE, 20'h00000, 16'h0000, 16'h0000);
    send_fields(REQ_READ, 20'h00000, 16'h0000, 16'hffff);
    send_fields(REQ_READ, 20'h00000, 16'h0000, 16'hffff);
    send_fields(REQ_PROG, 20'h00010, 16'h8001, 16'h0000);
    send_fields(REQ_READ, 20'h00000, 16'h0000, 16'h8001);
    // erase with blank check failing: zero programming starts
    send_fields(REQ_ERASE, 20'h00000, 16'h0000, 16'h0000);
    send_fields(REQ_READ, 20'h00000, 16'h0000, 16'h7fff);
    send_fields(REQ_READ, 20'h00000, 16'h0000, 16'h0000);
    send_fields(REQ_RESET, 20'h00000, 16'h0000, 16'h0000);

    // Zero size, zero retry limits, zero delays.
    write_all(21'd0, 6'd0, 12'd0, 16'd0, 16'd0, 16'd0);
    send_fields(REQ_ERASE, 20'h00000, 16'h0000, 16'h0000);
    send_fields(REQ_PROG, 20'h00002, 16'h00ff, 16'h0000);
    send_fields(REQ_READ, 20'h00000, 16'h0000, 16'h0000);
    // smallest array: erase fails at the erase limit
    drain();
    write_reg(CFG_FLASH_SIZE, 21'd2);
    send_fields(REQ_ERASE, 20'h00000, 16'h0000, 16'h0000);
    send_fields(REQ_READ, 20'h00000, 16'h0000, 16'h0000);
    send_fields(REQ_READ, 20'h00000, 16'h0000, 16'h0000);
    send_fields(REQ_READ, 20'h00000, 16'h0000, 16'h0001);

    // Odd size, top retry limits, top delays, one stretch with no idling.
    max_gap = 0;
    write_all(21'd3, 6'd63, 12'd4095, 16'hffff, 16'hffff, 16'hffff);
    run_cmd(REQ_ERASE);
    run_cmd(REQ_PROG);
    max_gap = 12;

    // Oversized size: capped to the address space.
    write_all(21'h1fffff, 6'd1, 12'd1, 16'd1, 16'd2, 16'd3);
    run_cmd(REQ_PROG);
    send_fields(REQ_ERASE, 20'h00000, 16'h0000, 16'h0000);
    send_fields(REQ_READ, 20'h00000, 16'h0000, 16'hffff);
    send_fields(REQ_RESET, 20'h00000, 16'h0000, 16'h0000);

    // Random part: random settings with small arrays.
    start_cnt = accepted_cnt;
    while (accepted_cnt - start_cnt < 50) begin
      max_gap = ($urandom_range(0, 4) == 0) ? 0 : 12;
      write_all(21'($urandom_range(0, 12)),
                ($urandom_range(0, 4) == 0) ? 6'd63 : 6'($urandom_range(0, 5)),
                ($urandom_range(0, 4) == 0) ? 12'd4095 : 12'($urandom_range(0, 3)),
                16'($urandom), 16'($urandom), 16'($urandom));
      repeat (3) begin
        case ($urandom_range(0, 5))
          0, 1, 2: kind = REQ_PROG;
          3, 4:    kind = REQ_ERASE;
          default: kind = ($urandom_range(0, 1) != 0) ? REQ_RESET : REQ_READ;
        endcase
        run_cmd(kind);
      end
    end

    drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
